// File: rtl/olirs_pkg.sv
// ----------------------------------------------------------------------------
// olirs_pkg: shared definitions of the ordered list
// Sizes, operation codes and the command word that drives the cell chain.
// ----------------------------------------------------------------------------
package olirs_pkg;

	// Capacity of the list and the widths that follow from it.
	localparam int CAPACITY = 128;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 8;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int DATA_W   = 32;
	localparam int OP_W     = 2;
	localparam int FIDX_W   = 7;
	localparam int COUNT_W  = 8;

	// Search results are encoded in groups of cells, then across groups.
	localparam int GRP_SIZE = 16;
	localparam int OFF_W    = $clog2(GRP_SIZE);
	localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GRP_W    = (NGRP > 1) ? $clog2(NGRP) : 1;

	// Operation codes of the request word.
	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	// What every cell does in a cycle.
	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_INSERT,
		CMD_REMOVE,
		CMD_SEARCH
	} cmd_kind_t;

	// Command broadcast to the whole chain.
	typedef struct packed {
		cmd_kind_t          kind;
		logic [CMP_W-1:0]   pos;
		logic [CMP_W-1:0]   count;
		logic [DATA_W-1:0]  value;
	} cell_cmd_t;

	// Lowest hit inside one group of cells.
	typedef struct packed {
		logic               hit;
		logic [OFF_W-1:0]   off;
	} grp_hit_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_MATCH = 3'b010,
		ST_GROUP = 3'b100
	} state_t;

endpackage

// File: rtl/olirs_req_if.sv
// ----------------------------------------------------------------------------
// olirs_req_if: request channel of the ordered list
// Carries one operation word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface olirs_req_if;

	logic                           valid;
	logic                           ready;
	logic [olirs_pkg::OP_W-1:0]     op;
	logic [olirs_pkg::POS_W-1:0]    position;
	logic signed [olirs_pkg::DATA_W-1:0] value;

	modport source (output valid, output op, output position, output value, input ready);
	modport sink   (input valid, input op, input position, input value, output ready);

endinterface

// File: rtl/olirs_rsp_if.sv
// ----------------------------------------------------------------------------
// olirs_rsp_if: response channel of the ordered list
// Carries one result word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface olirs_rsp_if;

	logic                           valid;
	logic                           ready;
	logic                           status;
	logic [olirs_pkg::FIDX_W-1:0]   found_index;
	logic [olirs_pkg::COUNT_W-1:0]  count;

	modport source (output valid, output status, output found_index, output count,
		input ready);
	modport sink   (input valid, input status, input found_index, input count,
		output ready);

endinterface

// File: rtl/olirs_cell.sv
// ----------------------------------------------------------------------------
// olirs_cell: one entry of the list
// Holds one value, takes it from a neighbor on insert or remove, and
// compares it against the search value.
// ----------------------------------------------------------------------------
module olirs_cell (
	input  logic                           clk,
	input  olirs_pkg::cell_cmd_t           cmd,
	input  logic [olirs_pkg::IDX_W-1:0]    idx,
	input  logic [olirs_pkg::DATA_W-1:0]   left,
	input  logic [olirs_pkg::DATA_W-1:0]   right,
	output logic [olirs_pkg::DATA_W-1:0]   data,
	output logic                           match
);

	logic [olirs_pkg::DATA_W-1:0] data_q;
	logic                         match_q;
	logic [olirs_pkg::CMP_W-1:0]  idx_w;

	assign idx_w = olirs_pkg::CMP_W'(idx);

	// Shift up from the left on insert, down from the right on remove.
	always_ff @(posedge clk) begin
		case (cmd.kind)
			olirs_pkg::CMD_INSERT: begin
				if (idx_w > cmd.pos) begin
					data_q <= left;
				end else if (idx_w == cmd.pos) begin
					data_q <= cmd.value;
				end
			end
			olirs_pkg::CMD_REMOVE: begin
				if (idx_w >= cmd.pos) begin
					data_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	// Only entries below the count take part in a search.
	always_ff @(posedge clk) begin
		if (cmd.kind == olirs_pkg::CMD_SEARCH) begin
			match_q <= (idx_w < cmd.count) && (data_q == cmd.value);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

// File: rtl/olirs_prio.sv
// ----------------------------------------------------------------------------
// olirs_prio: group priority encoder
// Finds the lowest set match bit of one group of cells.
// ----------------------------------------------------------------------------
module olirs_prio (
	input  logic [olirs_pkg::GRP_SIZE-1:0] bits,
	output olirs_pkg::grp_hit_t            result
);

	// Scan from the top so the lowest set bit wins.
	always_comb begin
		result.hit = |bits;
		result.off = '0;
		for (int b = olirs_pkg::GRP_SIZE - 1; b >= 0; b--) begin
			if (bits[b]) begin
				result.off = olirs_pkg::OFF_W'(b);
			end
		end
	end

endmodule

// File: rtl/ordered_list_insert_remove_search.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_search: fixed-capacity ordered list
// A chain of cells holds the entries; append, insert and remove move affected
// entries at once, and search compares each entry then encodes the lowest hit.
// ----------------------------------------------------------------------------
//
//  channel  dir  fields                         handshake
//  req      in   op, position, value            valid / ready
//  rsp      out  status, found_index, count     valid / ready
//
// Append, insert and remove finish on the edge that accepts the word: the cells
// shift and the result word is loaded into the output register.
// Search goes through cell compare, group encode and group select, in order.
// Reset clears the count, sequencer and output valid; cells need no clearing.
// A new word is taken while idle and the output register is empty or drains.
//
module ordered_list_insert_remove_search (
	input  logic        clk,
	input  logic        arst_n,
	olirs_req_if.sink   req,
	olirs_rsp_if.source rsp
);

	localparam int PAD = olirs_pkg::NGRP * olirs_pkg::GRP_SIZE;

	olirs_pkg::state_t                 state_q;
	logic [olirs_pkg::CNT_W-1:0]       count_q;
	logic                              rsp_valid_q;
	logic                              rsp_status_q;
	logic [olirs_pkg::FIDX_W-1:0]      rsp_found_q;
	logic [olirs_pkg::COUNT_W-1:0]     rsp_count_q;
	olirs_pkg::grp_hit_t               grp_s2 [olirs_pkg::NGRP];

	olirs_pkg::cell_cmd_t              cmd;
	logic                              accept;
	logic [olirs_pkg::CMP_W-1:0]       pos_w;
	logic [olirs_pkg::CMP_W-1:0]       cnt_w;
	logic                              not_full;
	logic                              ok;
	logic [olirs_pkg::CNT_W-1:0]       count_next;
	logic [olirs_pkg::DATA_W-1:0]      cell_data [olirs_pkg::CAPACITY];
	logic [PAD-1:0]                    match_all;
	olirs_pkg::grp_hit_t               grp_hit [olirs_pkg::NGRP];
	logic [olirs_pkg::GRP_W-1:0]       sel_grp;
	logic [olirs_pkg::OFF_W-1:0]       sel_off;
	logic                              sel_hit;
	logic [31:0]                       hit_wide;
	logic [31:0]                       cnt_wide;
	logic [31:0]                       cnt_next_wide;

	assign req.ready = (state_q == olirs_pkg::ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	// Range checks of the request.
	assign pos_w    = olirs_pkg::CMP_W'(req.position);
	assign cnt_w    = olirs_pkg::CMP_W'(count_q);
	assign not_full = cnt_w < olirs_pkg::CMP_W'(olirs_pkg::CAPACITY);

	always_comb begin
		cmd.kind   = olirs_pkg::CMD_NONE;
		cmd.pos    = pos_w;
		cmd.count  = cnt_w;
		cmd.value  = req.value;
		ok         = 1'b0;
		count_next = count_q;
		if (accept) begin
			case (olirs_pkg::op_t'(req.op))
				olirs_pkg::OP_APPEND: begin
					ok      = not_full;
					cmd.pos = cnt_w;
					if (ok) begin
						cmd.kind   = olirs_pkg::CMD_INSERT;
						count_next = count_q + olirs_pkg::CNT_W'(1);
					end
				end
				olirs_pkg::OP_INSERT: begin
					ok = not_full && (pos_w <= cnt_w);
					if (ok) begin
						cmd.kind   = olirs_pkg::CMD_INSERT;
						count_next = count_q + olirs_pkg::CNT_W'(1);
					end
				end
				olirs_pkg::OP_REMOVE: begin
					ok = pos_w < cnt_w;
					if (ok) begin
						cmd.kind   = olirs_pkg::CMD_REMOVE;
						count_next = count_q - olirs_pkg::CNT_W'(1);
					end
				end
				default: begin
					cmd.kind = olirs_pkg::CMD_SEARCH;
				end
			endcase
		end
	end

	// Chain of entry cells.
	for (genvar i = 0; i < olirs_pkg::CAPACITY; i++) begin : g_cell
		logic [olirs_pkg::DATA_W-1:0] left_d;
		logic [olirs_pkg::DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = req.value;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == olirs_pkg::CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		olirs_cell u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.idx   (olirs_pkg::IDX_W'(i)),
			.left  (left_d),
			.right (right_d),
			.data  (cell_data[i]),
			.match (match_all[i])
		);
	end

	for (genvar i = olirs_pkg::CAPACITY; i < PAD; i++) begin : g_pad
		assign match_all[i] = 1'b0;
	end

	// Group encoders over the registered match bits.
	for (genvar g = 0; g < olirs_pkg::NGRP; g++) begin : g_grp
		olirs_prio u_prio (
			.bits   (match_all[g*olirs_pkg::GRP_SIZE +: olirs_pkg::GRP_SIZE]),
			.result (grp_hit[g])
		);
	end

	always_ff @(posedge clk) begin
		if (state_q == olirs_pkg::ST_MATCH) begin
			grp_s2 <= grp_hit;
		end
	end

	// Lowest group with a hit.
	always_comb begin
		sel_hit = 1'b0;
		sel_grp = '0;
		sel_off = '0;
		for (int g = olirs_pkg::NGRP - 1; g >= 0; g--) begin
			if (grp_s2[g].hit) begin
				sel_hit = 1'b1;
				sel_grp = olirs_pkg::GRP_W'(g);
				sel_off = grp_s2[g].off;
			end
		end
	end

	assign hit_wide      = 32'({sel_grp, sel_off});
	assign cnt_wide      = 32'(count_q);
	assign cnt_next_wide = 32'(count_next);

	// Sequencer and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olirs_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			count_q <= count_next;
			case (state_q)
				olirs_pkg::ST_IDLE: begin
					if (cmd.kind == olirs_pkg::CMD_SEARCH) begin
						state_q <= olirs_pkg::ST_MATCH;
					end
				end
				olirs_pkg::ST_MATCH: begin
					state_q <= olirs_pkg::ST_GROUP;
				end
				default: begin
					state_q <= olirs_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((accept && cmd.kind != olirs_pkg::CMD_SEARCH)
				|| state_q == olirs_pkg::ST_GROUP) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept && cmd.kind != olirs_pkg::CMD_SEARCH) begin
			rsp_status_q <= !ok;
			rsp_found_q  <= '0;
			rsp_count_q  <= cnt_next_wide[olirs_pkg::COUNT_W-1:0];
		end else if (state_q == olirs_pkg::ST_GROUP) begin
			rsp_status_q <= !sel_hit;
			rsp_found_q  <= sel_hit ? hit_wide[olirs_pkg::FIDX_W-1:0] : '0;
			rsp_count_q  <= cnt_wide[olirs_pkg::COUNT_W-1:0];
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.found_index = rsp_found_q;
	assign rsp.count       = rsp_count_q;

endmodule

// File: tb/olirs_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// olirs_list_checker: result checker of the ordered list
// Watches the request and response channels, keeps its own copy of the list
// and of the entry count, and compares every result word against the oldest
// predicted result. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module olirs_list_checker (
	input  logic        clk,
	input  logic        arst_n,
	olirs_req_if        req,
	olirs_rsp_if        rsp,
	output int unsigned error_count,
	output int unsigned outstanding,
	output int unsigned list_len
);
	import olirs_pkg::*;

	typedef struct packed {
		logic               status;
		logic [FIDX_W-1:0]  found_index;
		logic [COUNT_W-1:0] count;
	} list_result_t;

	// Shadow copy of the list contents; list_len holds the entry count.
	logic [DATA_W-1:0] list_mem [CAPACITY];
	list_result_t      expected_results [$];

	// Prints one line per failure and counts it.
	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	// Applies one operation to the shadow list and works out its result word.
	task automatic predict_list_op(input op_t op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val, output list_result_t res);
		int unsigned i;
		res.status      = 1'b1;
		res.found_index = '0;
		case (op)
			OP_APPEND: begin
				if (list_len < CAPACITY) begin
					list_mem[list_len] = val;
					list_len++;
					res.status = 1'b0;
				end
			end
			OP_INSERT: begin
				if (pos <= list_len && list_len < CAPACITY) begin
					for (i = list_len; i > pos; i--) begin
						list_mem[i] = list_mem[i - 1];
					end
					list_mem[pos] = val;
					list_len++;
					res.status = 1'b0;
				end
			end
			OP_REMOVE: begin
				if (pos < list_len) begin
					for (i = pos; i + 1 < list_len; i++) begin
						list_mem[i] = list_mem[i + 1];
					end
					list_len--;
					res.status = 1'b0;
				end
			end
			default: begin
				// The lowest matching index wins.
				for (i = 0; i < list_len; i++) begin
					if (list_mem[i] == val) begin
						res.found_index = FIDX_W'(i);
						res.status      = 1'b0;
						break;
					end
				end
			end
		endcase
		res.count = COUNT_W'(list_len);
	endtask

	// Result words are checked before the request of the same edge is
	// predicted, since a word can never answer a request taken on that edge.
	always @(posedge clk or negedge arst_n) begin : watch
		list_result_t want;
		if (!arst_n) begin
			list_len    = 0;
			error_count = 0;
			outstanding = 0;
			expected_results.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_error($sformatf(
						"result word with no request waiting (status %0d, index %0d, count %0d)",
						rsp.status, rsp.found_index, rsp.count));
				end else begin
					want = expected_results.pop_front();
					if (rsp.status !== want.status) begin
						report_error($sformatf("status: expected %0d, got %0d",
							want.status, rsp.status));
					end
					if (rsp.found_index !== want.found_index) begin
						report_error($sformatf("found_index: expected %0d, got %0d",
							want.found_index, rsp.found_index));
					end
					if (rsp.count !== want.count) begin
						report_error($sformatf("count: expected %0d, got %0d",
							want.count, rsp.count));
					end
				end
			end
			if (req.valid && req.ready) begin
				predict_list_op(op_t'(req.op), req.position, req.value, want);
				expected_results.push_back(want);
			end
			outstanding = expected_results.size();
		end
	end

endmodule

// File: tb/tb_ordered_list_insert_remove_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_remove_search: testbench of the ordered list
// Drives directed and random append, insert, remove and search words with
// random gaps and stalls on both channels; the checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_ordered_list_insert_remove_search;
	import olirs_pkg::*;

	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASE_WORDS     = 138;
	localparam int NUM_PHASES      = 13;
	localparam int POOL_SIZE       = 8;
	localparam logic [DATA_W-1:0] TAIL_MARK = 32'h5A5A_A5A5;

	typedef enum {PH_GROW, PH_SHRINK, PH_MIXED} phase_kind_t;

	logic        clk;
	logic        arst_n;
	logic        hold_off_req  = 1'b0;
	int unsigned send_idle_pct = 20;
	int unsigned rsp_stall_pct = 20;
	int unsigned error_count;
	int unsigned outstanding;
	int unsigned list_len;
	logic [DATA_W-1:0] value_pool [POOL_SIZE];

	olirs_req_if req_ch ();
	olirs_rsp_if rsp_ch ();

	ordered_list_insert_remove_search u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	olirs_list_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.error_count (error_count),
		.outstanding (outstanding),
		.list_len    (list_len)
	);

	// Clock of 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(8, 40);
		end
		return $urandom_range(1, 3);
	endfunction

	// Half of the values come from a small pool so searches hit and repeat.
	function automatic logic [DATA_W-1:0] pick_value();
		if ($urandom_range(0, 1) == 0) begin
			return value_pool[$urandom_range(0, POOL_SIZE - 1)];
		end
		return $urandom();
	endfunction

	function automatic op_t pick_op(input phase_kind_t kind);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (kind)
			PH_GROW: begin
				if (r < 35) return OP_APPEND;
				if (r < 70) return OP_INSERT;
				if (r < 80) return OP_REMOVE;
			end
			PH_SHRINK: begin
				if (r < 10) return OP_APPEND;
				if (r < 20) return OP_INSERT;
				if (r < 75) return OP_REMOVE;
			end
			default: begin
				if (r < 20) return OP_APPEND;
				if (r < 45) return OP_INSERT;
				if (r < 75) return OP_REMOVE;
			end
		endcase
		return OP_SEARCH;
	endfunction

	// Insert and remove positions are mostly in range for the current count, the rest anywhere.
	function automatic logic [POS_W-1:0] pick_position(input op_t op);
		if ($urandom_range(0, 99) < 85) begin
			if (op == OP_INSERT) begin
				return POS_W'($urandom_range(0, list_len));
			end
			if (op == OP_REMOVE && list_len > 0) begin
				return POS_W'($urandom_range(0, list_len - 1));
			end
		end
		return POS_W'($urandom_range(0, 255));
	endfunction

	// Offers one request word at a falling edge and holds it until taken.
	// Returns at a falling edge, after an optional idle gap.
	task automatic issue(input op_t op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val);
		int unsigned gap;
		req_ch.valid    <= 1'b1;
		req_ch.op       <= op;
		req_ch.position <= pos;
		req_ch.value    <= val;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			gap = pick_gap();
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Result side: random stalls, and one long hold-off when asked for.
	initial begin : result_ready
		int unsigned stall_left;
		stall_left   = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left   = HOLD_OFF_CYCLES;
			end
			if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
				stall_left   = pick_gap() - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus and verdict.
	initial begin : stimulus
		int unsigned phase;
		int unsigned n;
		phase_kind_t kind;
		op_t         op;
		req_ch.valid    = 1'b0;
		req_ch.op       = OP_APPEND;
		req_ch.position = '0;
		req_ch.value    = '0;
		arst_n          = 1'b0;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		for (n = 4; n < POOL_SIZE; n++) begin
			value_pool[n] = $urandom();
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty list: search misses, remove and insert past the end are rejected.
		issue(OP_SEARCH, 8'd0, 32'd0);
		issue(OP_REMOVE, 8'd0, 32'd0);
		issue(OP_INSERT, 8'd1, 32'd7);
		// Insert at the count of an empty list acts as an append.
		issue(OP_INSERT, 8'd0, 32'd7);
		issue(OP_APPEND, 8'hFF, 32'h8000_0000);
		issue(OP_APPEND, 8'h00, 32'h7FFF_FFFF);
		issue(OP_APPEND, 8'h00, 32'hFFFF_FFFF);
		issue(OP_INSERT, 8'd1, 32'd5);
		issue(OP_INSERT, POS_W'(list_len), 32'd0);
		issue(OP_APPEND, 8'h00, 32'd5);
		issue(OP_INSERT, 8'hFF, 32'd9);
		// Searches for the extremes, a duplicate and a missing value.
		issue(OP_SEARCH, 8'hFF, 32'h8000_0000);
		issue(OP_SEARCH, 8'h00, 32'h7FFF_FFFF);
		issue(OP_SEARCH, 8'h00, 32'hFFFF_FFFF);
		issue(OP_SEARCH, 8'h00, 32'd5);
		issue(OP_SEARCH, 8'h00, 32'd12345);
		// Removes out of range, at the head, at the tail and in the middle.
		issue(OP_REMOVE, 8'hFF, 32'd0);
		issue(OP_REMOVE, POS_W'(list_len), 32'd0);
		issue(OP_REMOVE, 8'd0, 32'd0);
		issue(OP_REMOVE, POS_W'(list_len - 1), 32'd0);
		issue(OP_REMOVE, 8'd1, 32'd0);

		// Fill the list, mark the last entry, then hit it while full.
		while (list_len < CAPACITY - 1) begin
			issue(OP_APPEND, POS_W'($urandom_range(0, 255)), $urandom());
		end
		issue(OP_APPEND, 8'd0, TAIL_MARK);
		issue(OP_APPEND, 8'd0, 32'd1);
		issue(OP_INSERT, 8'd0, 32'd1);
		issue(OP_INSERT, POS_W'(list_len), 32'd1);
		issue(OP_SEARCH, 8'd0, TAIL_MARK);
		issue(OP_REMOVE, POS_W'(CAPACITY - 1), 32'd0);
		issue(OP_REMOVE, 8'd0, 32'd0);

		// Random phases that push the list toward full, toward empty, or mix.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase % 6)
				0, 1: kind = PH_GROW;
				3, 4: kind = PH_SHRINK;
				default: kind = PH_MIXED;
			endcase
			if (phase % 6 == 5) begin
				send_idle_pct = 0;
				rsp_stall_pct = 0;
			end else begin
				send_idle_pct = $urandom_range(5, 40);
				rsp_stall_pct = $urandom_range(5, 40);
			end
			// Back-to-back requests against a long result hold-off.
			if (phase == 2) begin
				send_idle_pct = 0;
				hold_off_req  = 1'b1;
			end
			// Let the block drain completely before going on.
			if (phase == 7) begin
				req_ch.valid <= 1'b0;
				wait (outstanding == 0);
				@(negedge clk);
			end
			for (n = 0; n < PHASE_WORDS; n++) begin
				op = pick_op(kind);
				issue(op, pick_position(op), pick_value());
			end
		end

		req_ch.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
